@@ sv/clps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clps_pkg - shared definitions for the command parsed lifo stack
// stack sizing, result status codes and the controller to datapath bundles
// ----------------------------------------------------------------------------
package clps_pkg;

  localparam int STACK_DEPTH = 5;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int VAL_W       = 32;
  localparam int STAT_W      = 3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_PUSHED     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_POPPED     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL       = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY      = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ILLEGAL    = 3'd4;
  localparam logic [STAT_W-1:0] STAT_SHOW       = 3'd5;
  localparam logic [STAT_W-1:0] STAT_SHOW_EMPTY = 3'd6;

  // result value source
  localparam logic [1:0] VAL_ZERO = 2'd0;
  localparam logic [1:0] VAL_ACC  = 2'd1;
  localparam logic [1:0] VAL_MEM  = 2'd2;

  // stack read address source
  localparam logic [1:0] RD_TOP   = 2'd0;
  localparam logic [1:0] RD_FIRST = 2'd1;
  localparam logic [1:0] RD_NEXT  = 2'd2;

  typedef struct packed {
    logic               acc_digit;  // fold in_ch into the accumulator
    logic               acc_clear;
    logic               do_push;
    logic               do_pop;
    logic               rd_en;
    logic [1:0]         rd_sel;
    logic               emit;
    logic [STAT_W-1:0]  status;
    logic [1:0]         val_sel;
    logic               last_from_idx;
  } clps_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_full;
    logic idx_last;
  } clps_stat_t;

endpackage
`default_nettype wire

@@ sv/clps_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clps_datapath - stack memory, entry count, digit accumulator, result regs
// carries out the commands of the controller, reports stack fill status
// ----------------------------------------------------------------------------
module clps_datapath
  import clps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        in_ch,
  input  wire clps_cmd_t         cmd,
  output clps_stat_t             stat,
  output logic                   out_strobe,
  output logic [STAT_W-1:0]      out_status,
  output logic [VAL_W-1:0]       out_value,
  output logic                   out_last
);

  logic [VAL_W-1:0]  mem [STACK_DEPTH];
  logic [VAL_W-1:0]  rd_data_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic              strobe_r;
  logic [STAT_W-1:0] status_r;
  logic [VAL_W-1:0]  value_r;
  logic              last_r;
  logic [VAL_W-1:0]  val_mux;

  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.cnt_full = (cnt_r >= CNT_W'(STACK_DEPTH));
  assign stat.idx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  assign wr_addr = ADDR_W'(cnt_r);

  always_comb begin
    case (cmd.rd_sel)
      RD_TOP:   rd_addr = ADDR_W'(cnt_r - CNT_W'(1));
      RD_FIRST: rd_addr = '0;
      RD_NEXT:  rd_addr = idx_r + ADDR_W'(1);
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.do_push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.do_pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.rd_en) begin
      idx_nxt = rd_addr;
    end
  end

  // value * 10 + digit, wrapping at 32 bits
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_clear) begin
      acc_nxt = '0;
    end else if (cmd.acc_digit) begin
      acc_nxt = (acc_r << 3) + (acc_r << 1) + VAL_W'(in_ch[3:0]);
    end
  end

  always_comb begin
    case (cmd.val_sel)
      VAL_ACC: val_mux = acc_r;
      VAL_MEM: val_mux = rd_data_r;
      default: val_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.do_push) begin
      mem[wr_addr] <= acc_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      acc_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.emit) begin
      status_r <= cmd.status;
      value_r  <= val_mux;
      last_r   <= cmd.last_from_idx ? stat.idx_last : 1'b1;
    end
  end

  assign out_strobe = strobe_r;
  assign out_status = status_r;
  assign out_value  = value_r;
  assign out_last   = last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_push |-> !stat.cnt_full)
    else $error("push on full stack");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_pop |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("pop did not drop the entry count");

  a_next_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && cmd.rd_sel == RD_NEXT) |-> !stat.idx_last)
    else $error("show walk past top entry");

endmodule
`default_nettype wire

@@ sv/clps_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clps_ctrl - command text parser and line end sequencer
// tracks the command phase per character, feeds push digits to the datapath and acts at line end
// ----------------------------------------------------------------------------
module clps_ctrl
  import clps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_line_end,
  input  wire clps_stat_t  stat,
  output logic             busy,
  output clps_cmd_t        cmd
);

  localparam logic [7:0] CH_P   = 8'h70;
  localparam logic [7:0] CH_U   = 8'h75;
  localparam logic [7:0] CH_S   = 8'h73;
  localparam logic [7:0] CH_H   = 8'h68;
  localparam logic [7:0] CH_O   = 8'h6f;
  localparam logic [7:0] CH_W   = 8'h77;
  localparam logic [7:0] CH_LP  = 8'h28;
  localparam logic [7:0] CH_RP  = 8'h29;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  localparam logic [3:0] PH_START     = 4'd0;
  localparam logic [3:0] PH_P         = 4'd1;
  localparam logic [3:0] PH_PU        = 4'd2;
  localparam logic [3:0] PH_PUS       = 4'd3;
  localparam logic [3:0] PH_PUSH      = 4'd4;
  localparam logic [3:0] PH_DIGITS    = 4'd5;
  localparam logic [3:0] PH_PUSH_DONE = 4'd6;
  localparam logic [3:0] PH_PO        = 4'd7;
  localparam logic [3:0] PH_POP_DONE  = 4'd8;
  localparam logic [3:0] PH_S         = 4'd9;
  localparam logic [3:0] PH_SH        = 4'd10;
  localparam logic [3:0] PH_SHO       = 4'd11;
  localparam logic [3:0] PH_SHOW_DONE = 4'd12;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_PUSH = 2'd1;
  localparam logic [1:0] KIND_POP  = 2'd2;
  localparam logic [1:0] KIND_SHOW = 2'd3;

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_POP_OUT  = 2'd1;
  localparam logic [1:0] S_SHOW_OUT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [3:0] phase_r, phase_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       bad_r, bad_nxt;
  logic       accept;
  logic       is_digit;
  logic       legal_push, legal_pop, legal_show;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign is_digit = in_ch inside {[CH_0:CH_9]};

  assign legal_push = !bad_r && phase_r == PH_PUSH_DONE && kind_r == KIND_PUSH;
  assign legal_pop  = !bad_r && phase_r == PH_POP_DONE  && kind_r == KIND_POP;
  assign legal_show = !bad_r && phase_r == PH_SHOW_DONE && kind_r == KIND_SHOW;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    bad_nxt   = bad_r;
    cmd       = '0;
    cmd.status  = STAT_ILLEGAL;
    cmd.val_sel = VAL_ZERO;
    cmd.rd_sel  = RD_TOP;

    case (state_r)
      S_IDLE: begin
        if (accept && !in_line_end && !bad_r) begin
          // one parser step per character
          bad_nxt = 1'b1;
          case (phase_r)
            PH_START: begin
              if (in_ch == CH_P) begin
                phase_nxt = PH_P; bad_nxt = 1'b0;
              end else if (in_ch == CH_S) begin
                phase_nxt = PH_S; kind_nxt = KIND_SHOW; bad_nxt = 1'b0;
              end
            end
            PH_P: begin
              if (in_ch == CH_U) begin
                phase_nxt = PH_PU; kind_nxt = KIND_PUSH; bad_nxt = 1'b0;
              end else if (in_ch == CH_O) begin
                phase_nxt = PH_PO; kind_nxt = KIND_POP; bad_nxt = 1'b0;
              end
            end
            PH_PU: begin
              if (in_ch == CH_S) begin
                phase_nxt = PH_PUS; bad_nxt = 1'b0;
              end
            end
            PH_PUS: begin
              if (in_ch == CH_H) begin
                phase_nxt = PH_PUSH; bad_nxt = 1'b0;
              end
            end
            PH_PUSH: begin
              if (in_ch == CH_LP) begin
                phase_nxt = PH_DIGITS; bad_nxt = 1'b0;
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                cmd.acc_digit = 1'b1; bad_nxt = 1'b0;
              end else if (in_ch == CH_RP) begin
                phase_nxt = PH_PUSH_DONE; bad_nxt = 1'b0;
              end
            end
            PH_PO: begin
              if (in_ch == CH_P) begin
                phase_nxt = PH_POP_DONE; bad_nxt = 1'b0;
              end
            end
            PH_S: begin
              if (in_ch == CH_H) begin
                phase_nxt = PH_SH; bad_nxt = 1'b0;
              end
            end
            PH_SH: begin
              if (in_ch == CH_O) begin
                phase_nxt = PH_SHO; bad_nxt = 1'b0;
              end
            end
            PH_SHO: begin
              if (in_ch == CH_W) begin
                phase_nxt = PH_SHOW_DONE; bad_nxt = 1'b0;
              end
            end
            default: bad_nxt = 1'b1;
          endcase
        end else if (accept && in_line_end) begin
          // act on the line, then back to start of line
          phase_nxt     = PH_START;
          kind_nxt      = KIND_NONE;
          bad_nxt       = 1'b0;
          cmd.acc_clear = 1'b1;
          if (legal_push) begin
            cmd.emit = 1'b1;
            if (stat.cnt_full) begin
              cmd.status = STAT_FULL;
            end else begin
              cmd.do_push = 1'b1;
              cmd.status  = STAT_PUSHED;
              cmd.val_sel = VAL_ACC;
            end
          end else if (legal_pop) begin
            if (stat.cnt_zero) begin
              cmd.emit   = 1'b1;
              cmd.status = STAT_EMPTY;
            end else begin
              cmd.do_pop = 1'b1;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_TOP;
              state_nxt  = S_POP_OUT;
            end
          end else if (legal_show) begin
            if (stat.cnt_zero) begin
              cmd.emit   = 1'b1;
              cmd.status = STAT_SHOW_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_FIRST;
              state_nxt  = S_SHOW_OUT;
            end
          end else begin
            cmd.emit   = 1'b1;
            cmd.status = STAT_ILLEGAL;
          end
        end
      end
      S_POP_OUT: begin
        cmd.emit    = 1'b1;
        cmd.status  = STAT_POPPED;
        cmd.val_sel = VAL_MEM;
        state_nxt   = S_IDLE;
      end
      S_SHOW_OUT: begin
        cmd.emit          = 1'b1;
        cmd.status        = STAT_SHOW;
        cmd.val_sel       = VAL_MEM;
        cmd.last_from_idx = 1'b1;
        if (stat.idx_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_START;
      kind_r  <= KIND_NONE;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      bad_r   <= bad_nxt;
    end
  end

  a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP_OUT |=> state_r == S_IDLE)
    else $error("pop result state held");

  a_busy_no_parse: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.acc_digit && !cmd.do_push && !cmd.do_pop)
    else $error("stack or parser touched while busy");

  a_line_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_line_end) |=> phase_r == PH_START && !bad_r && kind_r == KIND_NONE)
    else $error("parser not back at start of line");

endmodule
`default_nettype wire

@@ sv/command_parsed_lifo_stack.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// command_parsed_lifo_stack - text command driven lifo stack
// parses push(n), pop and show lines and runs them on a small integer stack
// ----------------------------------------------------------------------------
// An item is one character (in_line_end low) or an end-of-line mark
// (in_line_end high, in_ch ignored); it is taken on a clock edge with start
// high and busy low. Characters are taken one per cycle while busy is low
// and never raise busy. At a line end the block answers with a status code
// on out_status, a value and a last flag, valid while out_strobe is high; the
// receiver cannot stall, so it must take every strobe. push, full, empty,
// illegal and show-empty answers come out the cycle after the line end and
// busy stays low. pop holds busy for one cycle and answers from the
// registered read of the top entry. show on N entries holds busy while it
// gives N results on consecutive cycles, bottom entry first, each from the
// registered read of the stack memory, so pop and show answer later than
// the other commands. Entries are unknown until pushed, but only pushed
// entries are ever read.
// ----------------------------------------------------------------------------
module command_parsed_lifo_stack
  import clps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [7:0]        in_ch,
  input  wire logic              in_line_end,
  output logic                   out_strobe,
  output logic [STAT_W-1:0]      out_status,
  output logic [VAL_W-1:0]       out_value,
  output logic                   out_last
);

  // controller to datapath command bundle and status back
  clps_cmd_t  cmd;
  clps_stat_t stat;

  // parser and line end sequencer
  clps_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_ch       (in_ch),
    .in_line_end (in_line_end),
    .stat        (stat),
    .busy        (busy),
    .cmd         (cmd)
  );

  // stack memory, count, accumulator and result registers
  clps_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_status (out_status),
    .out_value  (out_value),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire
